>>> src/sqi_pkg.sv
// ----------------------------------------------------------------------------
// sqi_pkg
// Shared widths, types and helpers for the segment / quad intersection pipeline.
// ----------------------------------------------------------------------------
package sqi_pkg;

   localparam int CW        = 21;                 // coordinate width
   localparam int NF        = CW - 2;             // normal fraction bits
   localparam int FIELD_W   = 63;                 // packed input field width
   localparam int EPS_W     = 20;                 // epsilon register width
   localparam logic [EPS_W-1:0] EPS_RESET = EPS_W'(1);
   localparam int STG_CNT   = 10;                 // pipeline register stages

   localparam int DW    = CW + 1;                 // coordinate difference
   localparam int NW    = 2 * DW + 1;             // triangle normal component
   localparam int DNW   = NW + CW + 2;            // triangle normal dot stored normal
   localparam int NSQW  = 2 * NW;                 // one squared normal component
   localparam int NNW   = 2 * NW + 2;             // squared length of triangle normal
   localparam int DN2W  = 2 * DNW;                // squared dot product
   localparam int CMPW  = DN2W + 16;              // cosine comparison width
   localparam int DDW   = CW + DW + 2;            // plane distance
   localparam int MW    = DDW;                    // plane distance magnitude
   localparam int DCW   = ((DDW > EPS_W + NF + 1) ? DDW : (EPS_W + NF + 1)) + 1;
   localparam int PW    = CW + DW + 1;            // stored normal cross edge
   localparam int AW    = DW + PW + 2;            // endpoint dot (n x e)
   localparam int MAW   = MW + AW + 1;            // magnitude times dot
   localparam int TW    = MAW + 1;                // edge sign term

   // Split points for the wide multiplications.
   localparam int NL    = NW / 2;
   localparam int NH    = NW - NL;
   localparam int DNL   = DNW / 2;
   localparam int DNH   = DNW - DNL;
   localparam int ML    = MW / 2;
   localparam int MH    = MW - ML;
   localparam int AL    = AW / 2;
   localparam int AH    = AW - AL;

   typedef logic signed [CW-1:0] coord_vec_type [3];

   typedef struct packed {
      logic [STG_CNT-1:0] en;
   } pipe_ctl_type;

   typedef enum logic [1:0] {
      OUT_MISMATCH = 2'd0,
      OUT_NO_CROSS = 2'd1,
      OUT_OUTSIDE  = 2'd2,
      OUT_INSIDE   = 2'd3
   } outcome_type;

   function automatic coord_vec_type to_vec(input logic [FIELD_W-1:0] f);
      coord_vec_type r;
      for (int k = 0; k < 3; k++) begin
         r[k] = $signed(f[k*CW +: CW]);
      end
      return r;
   endfunction

   // Constant multiplications written as shift and add.
   function automatic logic signed [CMPW-1:0] mul_c10000(input logic signed [CMPW-1:0] x);
      return (x <<< 13) + (x <<< 10) + (x <<< 9) + (x <<< 8) + (x <<< 4);
   endfunction

   function automatic logic signed [CMPW-1:0] mul_c9801(input logic signed [CMPW-1:0] x);
      return (x <<< 13) + (x <<< 10) + (x <<< 9) + (x <<< 6) + (x <<< 3) + x;
   endfunction

endpackage

>>> src/segment_quad_intersection.sv
// ----------------------------------------------------------------------------
// segment_quad_intersection
// Streaming segment versus convex quad test with exact integer arithmetic.
// ----------------------------------------------------------------------------
// The block takes one transaction per clock cycle while the result side is
// ready and returns one result transaction for each, in order. The rate is
// set by the ten-stage pipeline, in which every wide product is split into
// partial products no larger than about 45 by 22 or 35 by 34 bits and
// recombined in the following stage. Each stage has its own valid bit and
// advances whenever the stage after it is empty or moving, so the
// input side keeps accepting transactions while a result waits on the output
// until the pipeline is full. The epsilon register resets to one and should
// only be written while no transaction is in flight.
module segment_quad_intersection import sqi_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   // corner_a, corner_b, corner_c, corner_d, face_normal, seg_start, seg_end
   // (63 bits each, from bit 0 up), zero padded to 448 bits.
   input  logic [447:0]       req_tdata,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   // hit (bit 0), outcome (bits 2:1), zero padded to 8 bits.
   output logic [7:0]         rsp_tdata,
   input  logic               csr_we,
   input  logic [EPS_W-1:0]   csr_wdata
);

   logic [EPS_W-1:0]    eps_ff;
   logic [STG_CNT-1:0]  valid_ff;
   logic [STG_CNT-1:0]  valid_in;
   pipe_ctl_type        ctl;
   coord_vec_type       q [4];
   coord_vec_type       nv;
   coord_vec_type       s1;
   coord_vec_type       s2;
   logic                norm_ok;
   logic                no_cross;
   logic [MW-1:0]       m1;
   logic [MW-1:0]       m2;
   logic [3:0]          edge_neg;
   outcome_type         outcome_in;
   outcome_type         outcome_ff;
   logic                hit_ff;

   // Unpack the transaction fields into signed coordinate triples.
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         q[i] = to_vec(req_tdata[i*FIELD_W +: FIELD_W]);
      end
      nv = to_vec(req_tdata[4*FIELD_W +: FIELD_W]);
      s1 = to_vec(req_tdata[5*FIELD_W +: FIELD_W]);
      s2 = to_vec(req_tdata[6*FIELD_W +: FIELD_W]);
   end

   // A stage loads when it is empty or when the stage after it loads.
   always_comb begin
      ctl.en[STG_CNT-1] = !valid_ff[STG_CNT-1] || rsp_tready;
      for (int s = STG_CNT - 2; s >= 0; s--) begin
         ctl.en[s] = !valid_ff[s] || ctl.en[s+1];
      end
   end

   assign valid_in   = {valid_ff[STG_CNT-2:0], req_tvalid};
   assign req_tready = ctl.en[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         eps_ff   <= EPS_RESET;
      end else begin
         valid_ff <= (ctl.en & valid_in) | (~ctl.en & valid_ff);
         if (csr_we) begin
            eps_ff <= csr_wdata;
         end
      end
   end

   sqi_normal u_normal (
      .clock (clock),
      .ctl   (ctl),
      .qa    (q[0]),
      .qb    (q[1]),
      .qc    (q[2]),
      .nv    (nv),
      .ok_ff (norm_ok)
   );

   sqi_plane u_plane (
      .clock  (clock),
      .ctl    (ctl),
      .qa     (q[0]),
      .s1     (s1),
      .s2     (s2),
      .nv     (nv),
      .eps    (eps_ff),
      .m1_ff  (m1),
      .m2_ff  (m2),
      .nc_out (no_cross)
   );

   // One sign test for each directed edge a->b, b->c, c->d and d->a.
   for (genvar i = 0; i < 4; i++) begin : g_edge
      sqi_edge u_edge (
         .clock  (clock),
         .ctl    (ctl),
         .qa     (q[i]),
         .qb     (q[(i+1)%4]),
         .s1     (s1),
         .s2     (s2),
         .nv     (nv),
         .m1     (m1),
         .m2     (m2),
         .neg_ff (edge_neg[i])
      );
   end

   // The checks take priority in order: normal, plane crossing, edges.
   always_comb begin
      if (!norm_ok) begin
         outcome_in = OUT_MISMATCH;
      end else if (no_cross) begin
         outcome_in = OUT_NO_CROSS;
      end else if (|edge_neg) begin
         outcome_in = OUT_OUTSIDE;
      end else begin
         outcome_in = OUT_INSIDE;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.en[STG_CNT-1]) begin
         outcome_ff <= outcome_in;
         hit_ff     <= (outcome_in == OUT_INSIDE);
      end
   end

   assign rsp_tvalid = valid_ff[STG_CNT-1];
   assign rsp_tdata  = {5'b0, outcome_ff, hit_ff};

   // An accepted transaction always lands in the first stage.
   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> valid_ff[0])
      else $error("accepted transaction did not enter the pipeline");

   // A hit is reported exactly for the inside outcome.
   a_hit_inside: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (hit_ff == (outcome_ff == OUT_INSIDE)))
      else $error("hit flag disagrees with outcome");

   // A failed normal check always yields the mismatch outcome.
   a_mismatch: assert property (@(posedge clock) disable iff (reset)
      (valid_ff[STG_CNT-2] && ctl.en[STG_CNT-1] && !norm_ok)
      |=> (outcome_ff == OUT_MISMATCH))
      else $error("normal mismatch not reported");

   // A transaction held in the next-to-last stage is not lost while the output side stalls.
   a_no_loss: assert property (@(posedge clock) disable iff (reset)
      (valid_ff[STG_CNT-2] && !ctl.en[STG_CNT-2]) |=> valid_ff[STG_CNT-2])
      else $error("stalled stage dropped its transaction");

endmodule

>>> src/sqi_normal.sv
// ----------------------------------------------------------------------------
// sqi_normal
// Checks that the normal of triangle a,b,c agrees with the stored normal.
// ----------------------------------------------------------------------------
module sqi_normal import sqi_pkg::*; (
   input  logic          clock,
   input  pipe_ctl_type  ctl,
   input  coord_vec_type qa,
   input  coord_vec_type qb,
   input  coord_vec_type qc,
   input  coord_vec_type nv,
   output logic          ok_ff
);

   logic signed [CW-1:0]     n0_ff [3];
   logic signed [CW-1:0]     n1_ff [3];
   logic signed [CW-1:0]     n2_ff [3];
   logic signed [DW-1:0]     e1_in [3];
   logic signed [DW-1:0]     e1_ff [3];
   logic signed [DW-1:0]     e2_in [3];
   logic signed [DW-1:0]     e2_ff [3];
   logic signed [2*DW-1:0]   cp_in [6];
   logic signed [2*DW-1:0]   cp_ff [6];
   logic signed [NW-1:0]     nc_in [3];
   logic signed [NW-1:0]     nc_ff [3];
   logic signed [NW+CW-1:0]  dp_in [3];
   logic signed [NW+CW-1:0]  dp_ff [3];
   logic signed [2*NH-1:0]   sh_in [3];
   logic signed [2*NH-1:0]   sh_ff [3];
   logic signed [NH+NL:0]    sm_in [3];
   logic signed [NH+NL:0]    sm_ff [3];
   logic [2*NL-1:0]          sl_in [3];
   logic [2*NL-1:0]          sl_ff [3];
   logic signed [DNW-1:0]    dn_in;
   logic signed [DNW-1:0]    dn_ff;
   logic signed [NSQW-1:0]   sq_in [3];
   logic signed [NSQW-1:0]   sq_ff [3];
   logic signed [NNW-1:0]    nn_in;
   logic signed [NNW-1:0]    nn5_ff;
   logic signed [NNW-1:0]    nn6_ff;
   logic signed [2*DNH-1:0]  dh_in;
   logic signed [2*DNH-1:0]  dh_ff;
   logic signed [DNH+DNL:0]  dm_in;
   logic signed [DNH+DNL:0]  dm_ff;
   logic [2*DNL-1:0]         dl_in;
   logic [2*DNL-1:0]         dl_ff;
   logic                     pos_in;
   logic                     pos5_ff;
   logic                     pos6_ff;
   logic                     pos7_ff;
   logic signed [DN2W-1:0]   dn2_in;
   logic signed [DN2W-1:0]   dn2_ff;
   logic signed [CMPW-1:0]   lhs_in;
   logic signed [CMPW-1:0]   lhs_ff;
   logic signed [CMPW-1:0]   rhs_in;
   logic signed [CMPW-1:0]   rhs_ff;
   logic                     ok_in;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         e1_in[k] = DW'(qb[k]) - DW'(qa[k]);
         e2_in[k] = DW'(qc[k]) - DW'(qa[k]);
      end
      cp_in[0] = e1_ff[1] * e2_ff[2];
      cp_in[1] = e1_ff[2] * e2_ff[1];
      cp_in[2] = e1_ff[2] * e2_ff[0];
      cp_in[3] = e1_ff[0] * e2_ff[2];
      cp_in[4] = e1_ff[0] * e2_ff[1];
      cp_in[5] = e1_ff[1] * e2_ff[0];
      for (int k = 0; k < 3; k++) begin
         nc_in[k] = NW'(cp_ff[2*k]) - NW'(cp_ff[2*k+1]);
         dp_in[k] = nc_ff[k] * n2_ff[k];
         sh_in[k] = $signed(nc_ff[k][NW-1:NL]) * $signed(nc_ff[k][NW-1:NL]);
         sm_in[k] = $signed(nc_ff[k][NW-1:NL]) * $signed({1'b0, nc_ff[k][NL-1:0]});
         sl_in[k] = nc_ff[k][NL-1:0] * nc_ff[k][NL-1:0];
         sq_in[k] = (NSQW'(sh_ff[k]) <<< (2*NL)) + (NSQW'(sm_ff[k]) <<< (NL+1))
                  + NSQW'($signed({1'b0, sl_ff[k]}));
      end
      dn_in  = DNW'(dp_ff[0]) + DNW'(dp_ff[1]) + DNW'(dp_ff[2]);
      nn_in  = NNW'(sq_ff[0]) + NNW'(sq_ff[1]) + NNW'(sq_ff[2]);
      pos_in = (dn_ff > 0);
      dh_in  = $signed(dn_ff[DNW-1:DNL]) * $signed(dn_ff[DNW-1:DNL]);
      dm_in  = $signed(dn_ff[DNW-1:DNL]) * $signed({1'b0, dn_ff[DNL-1:0]});
      dl_in  = dn_ff[DNL-1:0] * dn_ff[DNL-1:0];
      dn2_in = (DN2W'(dh_ff) <<< (2*DNL)) + (DN2W'(dm_ff) <<< (DNL+1))
             + DN2W'($signed({1'b0, dl_ff}));
      lhs_in = mul_c10000(CMPW'(dn2_ff));
      rhs_in = mul_c9801(CMPW'(nn6_ff)) <<< (2*NF);
      ok_in  = pos7_ff && (lhs_ff >= rhs_ff);
   end

   always_ff @(posedge clock) begin
      if (ctl.en[0]) begin
         e1_ff <= e1_in;
         e2_ff <= e2_in;
         n0_ff <= nv;
      end
      if (ctl.en[1]) begin
         cp_ff <= cp_in;
         n1_ff <= n0_ff;
      end
      if (ctl.en[2]) begin
         nc_ff <= nc_in;
         n2_ff <= n1_ff;
      end
      if (ctl.en[3]) begin
         dp_ff <= dp_in;
         sh_ff <= sh_in;
         sm_ff <= sm_in;
         sl_ff <= sl_in;
      end
      if (ctl.en[4]) begin
         dn_ff <= dn_in;
         sq_ff <= sq_in;
      end
      if (ctl.en[5]) begin
         nn5_ff  <= nn_in;
         pos5_ff <= pos_in;
         dh_ff   <= dh_in;
         dm_ff   <= dm_in;
         dl_ff   <= dl_in;
      end
      if (ctl.en[6]) begin
         dn2_ff  <= dn2_in;
         nn6_ff  <= nn5_ff;
         pos6_ff <= pos5_ff;
      end
      if (ctl.en[7]) begin
         lhs_ff  <= lhs_in;
         rhs_ff  <= rhs_in;
         pos7_ff <= pos6_ff;
      end
      if (ctl.en[8]) begin
         ok_ff <= ok_in;
      end
   end

endmodule

>>> src/sqi_plane.sv
// ----------------------------------------------------------------------------
// sqi_plane
// Signed plane distances of both endpoints and the plane crossing check.
// ----------------------------------------------------------------------------
module sqi_plane import sqi_pkg::*; (
   input  logic             clock,
   input  pipe_ctl_type     ctl,
   input  coord_vec_type    qa,
   input  coord_vec_type    s1,
   input  coord_vec_type    s2,
   input  coord_vec_type    nv,
   input  logic [EPS_W-1:0] eps,
   output logic [MW-1:0]    m1_ff,
   output logic [MW-1:0]    m2_ff,
   output logic             nc_out
);

   logic signed [CW-1:0]     n0_ff [3];
   logic signed [DW-1:0]     u_in  [3];
   logic signed [DW-1:0]     u_ff  [3];
   logic signed [DW-1:0]     v_in  [3];
   logic signed [DW-1:0]     v_ff  [3];
   logic signed [CW+DW-1:0]  pu_in [3];
   logic signed [CW+DW-1:0]  pu_ff [3];
   logic signed [CW+DW-1:0]  pv_in [3];
   logic signed [CW+DW-1:0]  pv_ff [3];
   logic signed [DDW-1:0]    d1_in;
   logic signed [DDW-1:0]    d1_ff;
   logic signed [DDW-1:0]    d2_in;
   logic signed [DDW-1:0]    d2_ff;
   logic signed [DCW-1:0]    ex;
   logic signed [DCW-1:0]    d1x;
   logic signed [DCW-1:0]    d2x;
   logic [MW-1:0]            m1_in;
   logic [MW-1:0]            m2_in;
   logic [MW-1:0]            m13_ff;
   logic [MW-1:0]            m23_ff;
   logic                     nc_in;
   logic [8:3]               nc_ff;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         u_in[k]  = DW'(s1[k]) - DW'(qa[k]);
         v_in[k]  = DW'(s2[k]) - DW'(qa[k]);
         pu_in[k] = n0_ff[k] * u_ff[k];
         pv_in[k] = n0_ff[k] * v_ff[k];
      end
      d1_in = DDW'(pu_ff[0]) + DDW'(pu_ff[1]) + DDW'(pu_ff[2]);
      d2_in = DDW'(pv_ff[0]) + DDW'(pv_ff[1]) + DDW'(pv_ff[2]);
      ex    = DCW'($signed({1'b0, eps})) <<< NF;
      d1x   = DCW'(d1_ff);
      d2x   = DCW'(d2_ff);
      nc_in = ((d1x >= -ex) && (d2x >= -ex)) || ((d1x <= ex) && (d2x <= ex));
      m1_in = d1_ff[DDW-1] ? -d1_ff : d1_ff;
      m2_in = d2_ff[DDW-1] ? -d2_ff : d2_ff;
   end

   always_ff @(posedge clock) begin
      if (ctl.en[0]) begin
         u_ff  <= u_in;
         v_ff  <= v_in;
         n0_ff <= nv;
      end
      if (ctl.en[1]) begin
         pu_ff <= pu_in;
         pv_ff <= pv_in;
      end
      if (ctl.en[2]) begin
         d1_ff <= d1_in;
         d2_ff <= d2_in;
      end
      if (ctl.en[3]) begin
         m13_ff   <= m1_in;
         m23_ff   <= m2_in;
         nc_ff[3] <= nc_in;
      end
      if (ctl.en[4]) begin
         m1_ff <= m13_ff;
         m2_ff <= m23_ff;
      end
      for (int s = 4; s <= 8; s++) begin
         if (ctl.en[s]) begin
            nc_ff[s] <= nc_ff[s-1];
         end
      end
   end

   assign nc_out = nc_ff[8];

endmodule

>>> src/sqi_edge.sv
// ----------------------------------------------------------------------------
// sqi_edge
// Sign test of the crossing point against one directed quad edge.
// ----------------------------------------------------------------------------
module sqi_edge import sqi_pkg::*; (
   input  logic          clock,
   input  pipe_ctl_type  ctl,
   input  coord_vec_type qa,
   input  coord_vec_type qb,
   input  coord_vec_type s1,
   input  coord_vec_type s2,
   input  coord_vec_type nv,
   input  logic [MW-1:0] m1,
   input  logic [MW-1:0] m2,
   output logic          neg_ff
);

   // The test value n.(e x w) is evaluated as m2*(u.(n x e)) + m1*(v.(n x e)).
   logic signed [CW-1:0]       n0_ff [3];
   logic signed [DW-1:0]       e_in  [3];
   logic signed [DW-1:0]       e_ff  [3];
   logic signed [DW-1:0]       u_in  [3];
   logic signed [DW-1:0]       u0_ff [3];
   logic signed [DW-1:0]       u1_ff [3];
   logic signed [DW-1:0]       u2_ff [3];
   logic signed [DW-1:0]       v_in  [3];
   logic signed [DW-1:0]       v0_ff [3];
   logic signed [DW-1:0]       v1_ff [3];
   logic signed [DW-1:0]       v2_ff [3];
   logic signed [CW+DW-1:0]    pp_in [6];
   logic signed [CW+DW-1:0]    pp_ff [6];
   logic signed [PW-1:0]       p_in  [3];
   logic signed [PW-1:0]       p_ff  [3];
   logic signed [DW+PW-1:0]    au_in [3];
   logic signed [DW+PW-1:0]    au_ff [3];
   logic signed [DW+PW-1:0]    bv_in [3];
   logic signed [DW+PW-1:0]    bv_ff [3];
   logic signed [AW-1:0]       x_in  [2];
   logic signed [AW-1:0]       x_ff  [2];
   logic [MW-1:0]              mm    [2];
   logic signed [MH+AH:0]      hh_in [2];
   logic signed [MH+AH:0]      hh_ff [2];
   logic signed [MH+AL+1:0]    hl_in [2];
   logic signed [MH+AL+1:0]    hl_ff [2];
   logic signed [ML+AH:0]      lh_in [2];
   logic signed [ML+AH:0]      lh_ff [2];
   logic [ML+AL-1:0]           ll_in [2];
   logic [ML+AL-1:0]           ll_ff [2];
   logic signed [MAW-1:0]      t_in  [2];
   logic signed [MAW-1:0]      t_ff  [2];
   logic signed [TW-1:0]       sum;
   logic                       neg_in;
   logic                       neg7_ff;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         e_in[k] = DW'(qb[k]) - DW'(qa[k]);
         u_in[k] = DW'(s1[k]) - DW'(qa[k]);
         v_in[k] = DW'(s2[k]) - DW'(qa[k]);
      end
      pp_in[0] = n0_ff[1] * e_ff[2];
      pp_in[1] = n0_ff[2] * e_ff[1];
      pp_in[2] = n0_ff[2] * e_ff[0];
      pp_in[3] = n0_ff[0] * e_ff[2];
      pp_in[4] = n0_ff[0] * e_ff[1];
      pp_in[5] = n0_ff[1] * e_ff[0];
      for (int k = 0; k < 3; k++) begin
         p_in[k]  = PW'(pp_ff[2*k]) - PW'(pp_ff[2*k+1]);
         au_in[k] = u2_ff[k] * p_ff[k];
         bv_in[k] = v2_ff[k] * p_ff[k];
      end
      x_in[0] = AW'(au_ff[0]) + AW'(au_ff[1]) + AW'(au_ff[2]);
      x_in[1] = AW'(bv_ff[0]) + AW'(bv_ff[1]) + AW'(bv_ff[2]);
      mm[0]   = m2;
      mm[1]   = m1;
      for (int j = 0; j < 2; j++) begin
         hh_in[j] = $signed({1'b0, mm[j][MW-1:ML]}) * $signed(x_ff[j][AW-1:AL]);
         hl_in[j] = $signed({1'b0, mm[j][MW-1:ML]}) * $signed({1'b0, x_ff[j][AL-1:0]});
         lh_in[j] = $signed({1'b0, mm[j][ML-1:0]}) * $signed(x_ff[j][AW-1:AL]);
         ll_in[j] = mm[j][ML-1:0] * x_ff[j][AL-1:0];
         t_in[j]  = (MAW'(hh_ff[j]) <<< (ML+AL)) + (MAW'(hl_ff[j]) <<< ML)
                  + (MAW'(lh_ff[j]) <<< AL) + MAW'($signed({1'b0, ll_ff[j]}));
      end
      sum    = TW'(t_ff[0]) + TW'(t_ff[1]);
      neg_in = sum[TW-1];
   end

   always_ff @(posedge clock) begin
      if (ctl.en[0]) begin
         e_ff  <= e_in;
         u0_ff <= u_in;
         v0_ff <= v_in;
         n0_ff <= nv;
      end
      if (ctl.en[1]) begin
         pp_ff <= pp_in;
         u1_ff <= u0_ff;
         v1_ff <= v0_ff;
      end
      if (ctl.en[2]) begin
         p_ff  <= p_in;
         u2_ff <= u1_ff;
         v2_ff <= v1_ff;
      end
      if (ctl.en[3]) begin
         au_ff <= au_in;
         bv_ff <= bv_in;
      end
      if (ctl.en[4]) begin
         x_ff <= x_in;
      end
      if (ctl.en[5]) begin
         hh_ff <= hh_in;
         hl_ff <= hl_in;
         lh_ff <= lh_in;
         ll_ff <= ll_in;
      end
      if (ctl.en[6]) begin
         t_ff <= t_in;
      end
      if (ctl.en[7]) begin
         neg7_ff <= neg_in;
      end
      if (ctl.en[8]) begin
         neg_ff <= neg7_ff;
      end
   end

endmodule

>>> verif/segment_quad_intersection_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_quad_intersection_checker
// Watches both streams, predicts each result and compares it in order.
// ----------------------------------------------------------------------------
module segment_quad_intersection_checker import sqi_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   input  logic             req_tready,
   input  logic [447:0]     req_tdata,
   input  logic             rsp_tvalid,
   input  logic             rsp_tready,
   input  logic [7:0]       rsp_tdata,
   input  logic             csr_we,
   input  logic [EPS_W-1:0] csr_wdata,
   output int               fail_count,
   output int               pending
);

   typedef logic signed [191:0] wide_type;

   typedef struct packed {
      logic        hit;
      outcome_type outcome;
   } verdict_type;

   logic [EPS_W-1:0] tolerance;
   verdict_type      verdict_q[$];

   function automatic wide_type coord(input logic [62:0] f, input int k);
      logic signed [CW-1:0] c;
      c = f[k*CW +: CW];
      return wide_type'(c);
   endfunction

   function automatic outcome_type classify(input logic [447:0] d,
                                            input logic [EPS_W-1:0] eps);
      wide_type q[4][3], n[3], s1[3], s2[3], e1[3], e2[3], nc[3];
      wide_type dn, nn, d1, d2, lim, m1, m2, e[3], w[3], c[3], dt;
      int j;
      for (int i = 0; i < 4; i++)
         for (int k = 0; k < 3; k++) q[i][k] = coord(d[i*63 +: 63], k);
      for (int k = 0; k < 3; k++) begin
         n[k]  = coord(d[4*63 +: 63], k);
         s1[k] = coord(d[5*63 +: 63], k);
         s2[k] = coord(d[6*63 +: 63], k);
         e1[k] = q[1][k] - q[0][k];
         e2[k] = q[2][k] - q[0][k];
      end
      nc[0] = e1[1]*e2[2] - e1[2]*e2[1];
      nc[1] = e1[2]*e2[0] - e1[0]*e2[2];
      nc[2] = e1[0]*e2[1] - e1[1]*e2[0];
      dn = nc[0]*n[0] + nc[1]*n[1] + nc[2]*n[2];
      nn = nc[0]*nc[0] + nc[1]*nc[1] + nc[2]*nc[2];
      if (dn <= 0) return OUT_MISMATCH;
      if (dn*dn*10000 < ((nn*9801) <<< (2*NF))) return OUT_MISMATCH;
      d1 = 0;
      d2 = 0;
      for (int k = 0; k < 3; k++) begin
         d1 += n[k]*(s1[k]-q[0][k]);
         d2 += n[k]*(s2[k]-q[0][k]);
      end
      lim = wide_type'({1'b0, eps}) <<< NF;
      if ((d1 >= -lim && d2 >= -lim) || (d1 <= lim && d2 <= lim)) return OUT_NO_CROSS;
      m1 = d1 < 0 ? -d1 : d1;
      m2 = d2 < 0 ? -d2 : d2;
      for (int i = 0; i < 4; i++) begin
         j = (i + 1) % 4;
         for (int k = 0; k < 3; k++) begin
            e[k] = q[j][k] - q[i][k];
            w[k] = m2*(s1[k]-q[i][k]) + m1*(s2[k]-q[i][k]);
         end
         c[0] = e[1]*w[2] - e[2]*w[1];
         c[1] = e[2]*w[0] - e[0]*w[2];
         c[2] = e[0]*w[1] - e[1]*w[0];
         dt = n[0]*c[0] + n[1]*c[1] + n[2]*c[2];
         if (dt < 0) return OUT_OUTSIDE;
      end
      return OUT_INSIDE;
   endfunction

   task automatic report_mismatch(input string what);
      $display("checker: mismatch: %s", what);
      fail_count++;
   endtask

   assign pending = verdict_q.size();

   always @(posedge clock) begin
      verdict_type want, got;
      if (reset) begin
         tolerance  <= EPS_RESET;
         fail_count = 0;
         verdict_q.delete();
      end else begin
         if (req_tvalid && req_tready) begin
            want.outcome = classify(req_tdata, tolerance);
            want.hit = (want.outcome == OUT_INSIDE);
            verdict_q.insert(verdict_q.size(), want);
         end
         if (rsp_tvalid && rsp_tready) begin
            got.hit = rsp_tdata[0];
            got.outcome = outcome_type'(rsp_tdata[2:1]);
            if (verdict_q.size() == 0) begin
               report_mismatch("unexpected result");
            end else begin
               want = verdict_q.pop_front();
               if (got.hit != want.hit)
                  report_mismatch($sformatf("hit %0d want %0d", got.hit, want.hit));
               if (got.outcome != want.outcome)
                  report_mismatch($sformatf("outcome %0d want %0d",
                                            got.outcome, want.outcome));
            end
         end
         if (csr_we) tolerance <= csr_wdata;
      end
   end

endmodule

>>> verif/segment_quad_intersection_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_quad_intersection_tb
// Drives directed and random quad/segment tests under varying back-pressure.
// ----------------------------------------------------------------------------
module segment_quad_intersection_tb import sqi_pkg::*;;

   logic             clock = 0;
   logic             reset = 1;
   logic             req_tvalid = 0;
   logic             req_tready;
   logic [447:0]     req_tdata = '0;
   logic             rsp_tvalid;
   logic             rsp_tready = 0;
   logic [7:0]       rsp_tdata;
   logic             csr_we = 0;
   logic [EPS_W-1:0] csr_wdata = '0;
   int               fail_count, pending;
   int               send_idle, recv_idle, stuck;

   initial begin
      forever #6 clock = ~clock;
   end

   segment_quad_intersection DUT (.*);
   segment_quad_intersection_checker chk (.*);

   // The receiver stalls at a rate set per phase.
   always @(posedge clock) rsp_tready <= ($urandom_range(99) >= recv_idle);

   // Watchdog on cycles without any accepted transaction.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset) stuck <= 0;
      else stuck <= stuck + 1;
      if (stuck > 20000) begin
         $display("segment_quad_intersection_tb: done, errors");
         $finish;
      end
   end

   function automatic logic [62:0] pt(input int x, input int y, input int z);
      return {21'(z), 21'(y), 21'(x)};
   endfunction

   function automatic logic [20:0] rc(input int span);
      return 21'($signed($urandom_range(2*span)) - span);
   endfunction

   // A mostly planar quad in z=0 with normal mostly +z, segment crossing the plane.
   function automatic logic [447:0] make_case(input int span);
      logic [62:0] f[7];
      int h;
      h = 1 + $urandom_range(span);
      f[0] = pt(-h + $urandom_range(h/2), -h, 0);
      f[1] = pt(h, -h + $urandom_range(h/2), 0);
      f[2] = pt(h, h, $urandom_range(3) == 0 ? int'($urandom_range(4)) : 0);
      f[3] = pt(-h, h - $urandom_range(h/2), 0);
      f[4] = pt(0, 0, 1 << NF);
      if ($urandom_range(7) == 0) f[4] = {rc(1<<NF), rc(1<<NF), rc(1<<NF)};
      f[5] = {21'($urandom_range(4*h)), rc(2*h), rc(2*h)};
      f[5] = pt(int'($signed(rc(2*h))), int'($signed(rc(2*h))), 1 + $urandom_range(h));
      f[6] = pt(int'($signed(rc(2*h))), int'($signed(rc(2*h))),
                -int'($urandom_range(h)));
      if ($urandom_range(1)) begin
         f[0] = pt(-h, -h, 0);
         f[1] = pt(-h, h, 0);
      end
      return {f[6], f[5], f[4], f[3], f[2], f[1], f[0]};
   endfunction

   task automatic send(input logic [447:0] d);
      while ($urandom_range(99) < send_idle) begin
         req_tvalid <= 0;
         @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata  <= d;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic drain_and_write(input logic [EPS_W-1:0] v);
      req_tvalid <= 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (12) @(posedge clock);
      csr_we <= 1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 0;
   endtask

   task automatic random_run(input int count);
      logic [447:0] d;
      for (int i = 0; i < count; i++) begin
         case ($urandom_range(9))
            0: d = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                    $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
            1: d = make_case(1 << 19);
            default: d = make_case(($urandom_range(3) == 0) ? 1000 : 60);
         endcase
         d[447:441] = 7'($urandom);
         send(d);
      end
   endtask

   initial begin
      logic [62:0] sq[4];
      send_idle = 0;
      recv_idle = 0;
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      sq[0] = pt(-100, -100, 0); sq[1] = pt(100, -100, 0);
      sq[2] = pt(100, 100, 0);   sq[3] = pt(-100, 100, 0);
      // Inside hit, outside miss, edge touch, no crossing, epsilon touch.
      send({pt(0, 0, -50), pt(0, 0, 50), pt(0, 0, 1 << NF), sq[3], sq[2], sq[1], sq[0]});
      send({pt(300, 0, -50), pt(300, 0, 50), pt(0, 0, 1 << NF), sq[3], sq[2], sq[1], sq[0]});
      send({pt(100, 0, -50), pt(100, 0, 50), pt(0, 0, 1 << NF), sq[3], sq[2], sq[1], sq[0]});
      send({pt(0, 0, 20), pt(0, 0, 50), pt(0, 0, 1 << NF), sq[3], sq[2], sq[1], sq[0]});
      send({pt(0, 0, -1), pt(0, 0, 1), pt(0, 0, 1 << NF), sq[3], sq[2], sq[1], sq[0]});
      // Flipped normal, degenerate triangle, tilted normal, all zeros, all ones.
      send({pt(0, 0, -50), pt(0, 0, 50), pt(0, 0, -(1 << NF)), sq[3], sq[2], sq[1], sq[0]});
      send({pt(0, 0, -50), pt(0, 0, 50), pt(0, 0, 1 << NF), sq[3], sq[0], sq[0], sq[0]});
      send({pt(0, 0, -50), pt(0, 0, 50), pt(1 << 17, 0, 1 << NF), sq[3], sq[2], sq[1], sq[0]});
      send('0);
      send('1);
      send({pt(-1048576, 1048575, -1048576), pt(1048575, -1048576, 1048575),
            pt(0, 0, 1 << NF), pt(-1048576, 1048575, 0), pt(1048575, 1048575, 0),
            pt(1048575, -1048576, 0), pt(-1048576, -1048576, 0)});
      drain_and_write(0);
      send({pt(0, 0, -1), pt(0, 0, 1), pt(0, 0, 1 << NF), sq[3], sq[2], sq[1], sq[0]});
      send({pt(0, 0, 0), pt(0, 0, 1), pt(0, 0, 1 << NF), sq[3], sq[2], sq[1], sq[0]});
      random_run(40);
      drain_and_write(20'hFFFFF);
      send({pt(0, 0, -50), pt(0, 0, 50), pt(0, 0, 1 << NF), sq[3], sq[2], sq[1], sq[0]});
      random_run(30);
      drain_and_write(3);
      send_idle = 22; recv_idle = 87;
      random_run(180);
      drain_and_write($urandom_range(40));
      send_idle = 87; recv_idle = 22;
      random_run(150);
      drain_and_write(1);
      send_idle = 0; recv_idle = 0;
      random_run(150);
      req_tvalid <= 0;
      while (pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (fail_count == 0) $display("segment_quad_intersection_tb: done, clean");
      else $display("segment_quad_intersection_tb: done, errors");
      $finish;
   end

endmodule
